>>> rtl/text_console_scrollback_macros.svh
// Assertion helpers shared by the console RTL.
// Both expect clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_SCROLLBACK_MACROS_SVH
`define TEXT_CONSOLE_SCROLLBACK_MACROS_SVH

// Same-cycle implication.
`define TCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tcs_pkg.sv
`default_nettype none

package tcs_pkg;

  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_BACK = 2'd1;
  localparam logic [1:0] CMD_FWD  = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_FIRST = 8'd32;
  localparam logic [7:0] CH_LAST  = 8'd126;

  localparam logic [6:0] SPACE    = 7'd32;
  localparam int         TAB_STOP = 8;
  localparam int         QDEPTH   = 2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_NEWLINE,
    OP_RETURN,
    OP_BKSP,
    OP_TAB,
    OP_PRINT,
    OP_SCROLL_BACK,
    OP_SCROLL_FWD,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [6:0] ch;
    logic [9:0] amount;
    logic [4:0] row;
    logic [6:0] col;
    logic       in_range;
  } op_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_EXEC,
    ST_LINE,
    ST_READ
  } st_e;

endpackage

`default_nettype wire

>>> rtl/tcs_if.sv
`default_nettype none

interface tcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_code;
  logic [9:0] scroll_amount;
  logic [4:0] view_row;
  logic [6:0] view_col;

  modport source (output valid, cmd, char_code, scroll_amount, view_row, view_col,
                  input ready);
  modport sink   (input valid, cmd, char_code, scroll_amount, view_row, view_col,
                  output ready);
endinterface

interface tcs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cell_char;
  logic [4:0] cur_row;
  logic [6:0] cur_col;
  logic [8:0] view_back;
  logic       at_bottom;

  modport source (output valid, cell_char, cur_row, cur_col, view_back, at_bottom,
                  input ready);
  modport sink   (input valid, cell_char, cur_row, cur_col, view_back, at_bottom,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/tcs_front.sv
`default_nettype none

module tcs_front #(
  parameter int COLS = 80,
  parameter int ROWS = 24
) (
  tcs_in_if.sink              req_i,
  input  tcs_pkg::back_stat_t stat_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output tcs_pkg::op_t        push_data_o
);

  tcs_pkg::op_e op;

  always_comb begin
    op = tcs_pkg::OP_NOP;
    unique case (req_i.cmd)
      tcs_pkg::CMD_PUT: begin
        unique case (req_i.char_code)
          tcs_pkg::CH_FF:  op = tcs_pkg::OP_CLEAR;
          tcs_pkg::CH_LF:  op = tcs_pkg::OP_NEWLINE;
          tcs_pkg::CH_CR:  op = tcs_pkg::OP_RETURN;
          tcs_pkg::CH_BS:  op = tcs_pkg::OP_BKSP;
          tcs_pkg::CH_TAB: op = tcs_pkg::OP_TAB;
          default: begin
            if (req_i.char_code >= tcs_pkg::CH_FIRST && req_i.char_code <= tcs_pkg::CH_LAST)
              op = tcs_pkg::OP_PRINT;
            else
              op = tcs_pkg::OP_NOP;
          end
        endcase
      end
      tcs_pkg::CMD_BACK: op = tcs_pkg::OP_SCROLL_BACK;
      tcs_pkg::CMD_FWD:  op = tcs_pkg::OP_SCROLL_FWD;
      tcs_pkg::CMD_READ: op = tcs_pkg::OP_READ;
      default:           op = tcs_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    push_data_o.op       = op;
    push_data_o.ch       = req_i.char_code[6:0];
    push_data_o.amount   = req_i.scroll_amount;
    push_data_o.row      = req_i.view_row;
    push_data_o.col      = req_i.view_col;
    push_data_o.in_range = (int'(req_i.view_row) < ROWS) && (int'(req_i.view_col) < COLS);
  end

  // hold off the host while the store is being wiped
  assign push_valid_o = req_i.valid && !stat_i.clearing;
  assign req_i.ready  = push_ready_i && !stat_i.clearing;

endmodule

`default_nettype wire

>>> rtl/tcs_queue.sv
`default_nettype none

module tcs_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  tcs_pkg::op_t push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output tcs_pkg::op_t pop_data_o
);

  localparam int PW = $clog2(tcs_pkg::QDEPTH);
  localparam int NW = $clog2(tcs_pkg::QDEPTH + 1);

  tcs_pkg::op_t ent_q [tcs_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign push_ready_o = (cnt_q != NW'(tcs_pkg::QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = ent_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (int'(wr_ptr_q) == tcs_pkg::QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (int'(rd_ptr_q) == tcs_pkg::QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

>>> rtl/tcs_back.sv
`default_nettype none

module tcs_back #(
  parameter int LINES = 512,
  parameter int COLS  = 80,
  parameter int ROWS  = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  tcs_pkg::op_t        pop_data_i,
  output tcs_pkg::back_stat_t stat_o,
  tcs_out_if.source           rsp_o
);

  localparam int DEPTH = LINES * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(LINES);
  localparam int FLW   = $clog2(LINES + 1);
  localparam int YW    = $clog2(ROWS);
  localparam int XW    = $clog2(COLS);
  localparam int TW    = XW + 1;
  localparam int CW    = $clog2(LINES + ROWS + 1024 + 1) + 1;
  localparam int WW    = $clog2(LINES + ROWS + 1) + 2;
  localparam int WRAPS = (ROWS + LINES - 1) / LINES + 1;

  localparam logic [LW-1:0]  RING0 = LW'(ROWS % LINES);
  localparam logic [AW-1:0]  BASE0 = AW'((ROWS % LINES) * COLS);
  localparam logic [FLW-1:0] FILL0 = FLW'((ROWS < LINES) ? ROWS : LINES);

  tcs_pkg::st_e   state_q, state_d;
  tcs_pkg::op_t   op_q, op_d;
  logic [LW-1:0]  ring_q, ring_d;
  logic [AW-1:0]  base_q, base_d;       // ring_q * COLS, kept incrementally
  logic [FLW-1:0] filled_q, filled_d;
  logic [LW-1:0]  bo_q, bo_d;
  logic [YW-1:0]  y_q, y_d;
  logic [XW-1:0]  x_q, x_d;
  logic [AW-1:0]  sweep_q, sweep_d;
  logic [XW-1:0]  ccnt_q, ccnt_d;
  logic           clr_reply_q, clr_reply_d;
  logic           out_valid_q;
  logic [6:0]     out_cell_q;
  logic [4:0]     out_row_q;
  logic [6:0]     out_col_q;
  logic [8:0]     out_back_q;
  logic           out_bot_q;

  logic [6:0]         mem [DEPTH];
  logic [6:0]         rd_q;
  logic               mem_we, mem_re, use_sweep;
  logic [6:0]         mem_wdata;
  logic [AW-1:0]      acc_addr, mem_waddr;
  logic signed [WW-1:0] line_v;
  logic [LW-1:0]      acc_line;
  logic [XW-1:0]      acc_col;
  logic [TW-1:0]      tab_t;
  logic [CW-1:0]      max_off, back_sum;
  logic [FLW-1:0]     fill_new;
  logic               load, next_row, need_line;
  logic [6:0]         cell_d;

  function automatic logic [LW-1:0] wrap_line(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] t;
    t = v;
    for (int i = 0; i < WRAPS; i++) begin
      if (t < 0) t = t + $signed(WW'(LINES));
    end
    return t[LW-1:0];
  endfunction

  // one shared address multiplier for the print write and the view read
  always_comb begin
    if (op_q.op == tcs_pkg::OP_READ) begin
      line_v  = WW'(ring_q) - WW'(bo_q) - WW'(ROWS) + WW'(op_q.row);
      acc_col = XW'(op_q.col);
    end else begin
      line_v  = WW'(ring_q) - WW'(ROWS) + WW'(y_q);
      acc_col = x_q;
    end
    acc_line = wrap_line(line_v);
    acc_addr = AW'(acc_line) * AW'(COLS) + AW'(acc_col);
  end

  assign tab_t    = (TW'(x_q) + TW'(tcs_pkg::TAB_STOP)) & ~TW'(tcs_pkg::TAB_STOP - 1);
  assign max_off  = (CW'(filled_q) >= CW'(ROWS)) ? CW'(filled_q) - CW'(ROWS) : '0;
  assign back_sum = CW'(bo_q) + CW'(op_q.amount);
  assign fill_new = (filled_q < FLW'(LINES)) ? filled_q + 1'b1 : filled_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ring_d      = ring_q;
    base_d      = base_q;
    filled_d    = filled_q;
    bo_d        = bo_q;
    y_d         = y_q;
    x_d         = x_q;
    sweep_d     = sweep_q;
    ccnt_d      = ccnt_q;
    clr_reply_d = clr_reply_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata   = tcs_pkg::SPACE;
    use_sweep   = 1'b0;
    load        = 1'b0;
    cell_d      = '0;
    pop_ready_o = 1'b0;
    next_row    = 1'b0;
    need_line   = 1'b0;

    unique case (state_q)
      tcs_pkg::ST_CLR: begin
        mem_we    = 1'b1;
        use_sweep = 1'b1;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == AW'(DEPTH - 1)) begin
          state_d = tcs_pkg::ST_IDLE;
          if (clr_reply_q) begin
            load        = 1'b1;
            clr_reply_d = 1'b0;
          end
        end
      end

      tcs_pkg::ST_IDLE: begin
        // only pop when the result slot is free, so the result can land later
        pop_ready_o = !out_valid_q || rsp_o.ready;
        if (pop_valid_i && pop_ready_o) begin
          op_d    = pop_data_i;
          state_d = tcs_pkg::ST_EXEC;
        end
      end

      tcs_pkg::ST_EXEC: begin
        state_d = tcs_pkg::ST_IDLE;
        load    = 1'b1;
        case (op_q.op)
          tcs_pkg::OP_CLEAR: begin
            ring_d      = RING0;
            base_d      = BASE0;
            filled_d    = FILL0;
            bo_d        = '0;
            y_d         = '0;
            x_d         = '0;
            sweep_d     = '0;
            clr_reply_d = 1'b1;
            load        = 1'b0;
            state_d     = tcs_pkg::ST_CLR;
          end
          tcs_pkg::OP_NEWLINE: begin
            next_row = 1'b1;
            bo_d     = '0;
          end
          tcs_pkg::OP_RETURN: x_d = '0;
          tcs_pkg::OP_BKSP: begin
            if (x_q != '0) x_d = x_q - 1'b1;
          end
          tcs_pkg::OP_TAB: begin
            if (tab_t >= TW'(COLS)) next_row = 1'b1;
            else                    x_d = XW'(tab_t);
          end
          tcs_pkg::OP_PRINT: begin
            mem_we    = 1'b1;
            mem_wdata = op_q.ch;
            if (TW'(x_q) + TW'(1) >= TW'(COLS)) next_row = 1'b1;
            else                                x_d = x_q + 1'b1;
            bo_d = '0;
          end
          tcs_pkg::OP_SCROLL_BACK: begin
            bo_d = (back_sum > max_off) ? LW'(max_off) : LW'(back_sum);
          end
          tcs_pkg::OP_SCROLL_FWD: begin
            if (CW'(op_q.amount) >= CW'(bo_q)) bo_d = '0;
            else                               bo_d = LW'(CW'(bo_q) - CW'(op_q.amount));
          end
          tcs_pkg::OP_READ: begin
            if (op_q.in_range) begin
              mem_re  = 1'b1;
              load    = 1'b0;
              state_d = tcs_pkg::ST_READ;
            end else begin
              cell_d = tcs_pkg::SPACE;
            end
          end
          default: ;
        endcase

        if (next_row) begin
          x_d = '0;
          if (y_q == YW'(ROWS - 1)) need_line = 1'b1;
          else                      y_d = y_q + 1'b1;
        end
        if (need_line) begin
          load    = 1'b0;
          sweep_d = base_q;
          ccnt_d  = '0;
          state_d = tcs_pkg::ST_LINE;
        end
      end

      tcs_pkg::ST_LINE: begin
        mem_we    = 1'b1;
        use_sweep = 1'b1;
        sweep_d   = sweep_q + 1'b1;
        ccnt_d    = ccnt_q + 1'b1;
        if (ccnt_q == XW'(COLS - 1)) begin
          if (ring_q == LW'(LINES - 1)) begin
            ring_d = '0;
            base_d = '0;
          end else begin
            ring_d = ring_q + 1'b1;
            base_d = base_q + AW'(COLS);
          end
          filled_d = fill_new;
          // keep a scrolled-back view on the same lines
          if (bo_q != '0 && CW'(bo_q) + CW'(ROWS) < CW'(fill_new)) bo_d = bo_q + 1'b1;
          load    = 1'b1;
          state_d = tcs_pkg::ST_IDLE;
        end
      end

      tcs_pkg::ST_READ: begin
        cell_d  = rd_q;
        load    = 1'b1;
        state_d = tcs_pkg::ST_IDLE;
      end

      default: state_d = tcs_pkg::ST_IDLE;
    endcase
  end

  assign mem_waddr       = use_sweep ? sweep_q : acc_addr;
  assign stat_o.clearing = (state_q == tcs_pkg::ST_CLR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcs_pkg::ST_CLR;
      ring_q      <= RING0;
      base_q      <= BASE0;
      filled_q    <= FILL0;
      bo_q        <= '0;
      y_q         <= '0;
      x_q         <= '0;
      sweep_q     <= '0;
      ccnt_q      <= '0;
      clr_reply_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ring_q      <= ring_d;
      base_q      <= base_d;
      filled_q    <= filled_d;
      bo_q        <= bo_d;
      y_q         <= y_d;
      x_q         <= x_d;
      sweep_q     <= sweep_d;
      ccnt_q      <= ccnt_d;
      clr_reply_q <= clr_reply_d;
      if (load)             out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    if (load) begin
      out_cell_q <= cell_d;
      out_row_q  <= 5'(y_d);
      out_col_q  <= 7'(x_d);
      out_back_q <= 9'(bo_d);
      out_bot_q  <= (bo_d == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[acc_addr];
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.cell_char = out_cell_q;
  assign rsp_o.cur_row   = out_row_q;
  assign rsp_o.cur_col   = out_col_q;
  assign rsp_o.view_back = out_back_q;
  assign rsp_o.at_bottom = out_bot_q;

endmodule

`default_nettype wire

>>> rtl/text_console_scrollback.sv
// Flow: each item from the queue is registered and executed, then its result is
// registered; an in-range read also passes the memory read register, and a new
// line is first cleared one cell per cycle. The execute unit takes a new item only
// once the last one is through and the result slot is free; a form feed clears all
// LINES * COLS cells of the store one cell per cycle. Reset: state returns to its
// initial values, then all cells are cleared with the input held not ready.
`default_nettype none
`include "text_console_scrollback_macros.svh"

module text_console_scrollback #(
  parameter int LINES = 512,
  parameter int COLS  = 80,
  parameter int ROWS  = 24
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  tcs_in_if.sink    req_i,
  tcs_out_if.source rsp_o
);

  tcs_pkg::back_stat_t stat;
  tcs_pkg::op_t        q_push_data, q_pop_data;
  logic                q_push_valid, q_push_ready;
  logic                q_pop_valid, q_pop_ready;

  tcs_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .req_i        (req_i),
    .stat_i       (stat),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_data_o  (q_push_data)
  );

  tcs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  tcs_back #(
    .LINES (LINES),
    .COLS  (COLS),
    .ROWS  (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_data_i  (q_pop_data),
    .stat_o      (stat),
    .rsp_o       (rsp_o)
  );

  `TCS_ASSERT_IMPL(a_no_accept_clr, stat.clearing, !req_i.ready, "beat accepted during clear")
  `TCS_ASSERT_IMPL(a_no_pop_clr, stat.clearing, !q_pop_ready, "queue popped during clear")
  `TCS_ASSERT_NEXT(a_one_op, q_pop_valid && q_pop_ready, !q_pop_ready, "back took two ops")
  `TCS_ASSERT_IMPL(a_cursor_rng, rsp_o.valid,
                   int'(rsp_o.cur_row) < ROWS && int'(rsp_o.cur_col) < COLS,
                   "cursor out of range")

endmodule

`default_nettype wire
